// ===== rtl/psm_pkg.sv =====
// Package for the page slot map: sizes, opcode and status codes, shared request struct.
// No dependencies.
`default_nettype none
package psm_pkg;
    localparam int Entries = 64;
    localparam int IdxW = $clog2(Entries);
    localparam int CntW = $clog2(Entries + 1);
    localparam int KeyW = 48;
    localparam int SlotW = 6;

    localparam logic [1:0] OpFind   = 2'd0;
    localparam logic [1:0] OpInsert = 2'd1;
    localparam logic [1:0] OpErase  = 2'd2;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StNotFnd  = 2'd1;
    localparam logic [1:0] StPresent = 2'd2;
    localparam logic [1:0] StFull    = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KeyW-1:0]  key;
        logic [SlotW-1:0] slot;
    } t_req;
endpackage
`default_nettype wire

// ===== rtl/psm_front.sv =====
// Front end: accepts request beats and queues them (two-entry FIFO).
// Depends on psm_pkg.
`default_nettype none
module psm_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  psm_pkg::t_req       i_req,
    output logic                o_valid,
    input  wire                 i_ready,
    output psm_pkg::t_req       o_req
);
    psm_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/psm_back.sv =====
// Back end: scans the entry store one entry per cycle, then applies the request.
// Depends on psm_pkg.
`default_nettype none
module psm_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  psm_pkg::t_req    i_req,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [1:0]       o_status,
    output logic [psm_pkg::SlotW-1:0] o_slot
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} t_state;
    t_state r_state;
    psm_pkg::t_req r_req;
    logic [psm_pkg::Entries-1:0] r_valid;
    logic [psm_pkg::KeyW-1:0]  r_key  [psm_pkg::Entries];
    logic [psm_pkg::SlotW-1:0] r_slotm [psm_pkg::Entries];
    logic [psm_pkg::CntW-1:0]  r_idx;
    logic [psm_pkg::IdxW-1:0]  r_hit, r_free;
    logic r_hit_ok, r_free_ok;
    logic [psm_pkg::KeyW-1:0]  r_rkey;
    logic [psm_pkg::SlotW-1:0] r_rslot;
    logic r_rvalid, r_rd;
    logic [psm_pkg::IdxW-1:0]  r_ridx;
    logic [psm_pkg::IdxW-1:0]  w_i;

    assign w_i = r_idx[psm_pkg::IdxW-1:0];
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        // registered memory read, one entry per cycle
        r_rkey  <= r_key[w_i];
        r_rslot <= r_slotm[w_i];
        r_rvalid <= r_valid[w_i];
        r_ridx <= w_i;
        if (r_state == S_APPLY && r_req.opcode == psm_pkg::OpInsert
            && !r_hit_ok && r_free_ok) begin
            r_key[r_free]   <= r_req.key;
            r_slotm[r_free] <= r_req.slot;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_rd <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req;
                        r_idx <= '0;
                        r_rd <= 1'b0;
                        r_hit_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx < psm_pkg::CntW'(psm_pkg::Entries)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_rd <= (r_idx < psm_pkg::CntW'(psm_pkg::Entries));
                    if (r_rd) begin
                        if (r_rvalid && r_rkey == r_req.key && !r_hit_ok) begin
                            r_hit_ok <= 1'b1;
                            r_hit <= r_ridx;
                            o_slot <= r_rslot;
                        end
                        if (!r_rvalid && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free <= r_ridx;
                        end
                    end
                    if (r_rd && r_idx == psm_pkg::CntW'(psm_pkg::Entries)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (!(r_req.opcode == psm_pkg::OpFind && r_hit_ok)) o_slot <= '0;
                    unique case (r_req.opcode)
                        psm_pkg::OpFind: begin
                            if (r_hit_ok) o_status <= psm_pkg::StOk;
                            else o_status <= psm_pkg::StNotFnd;
                        end
                        psm_pkg::OpInsert: begin
                            if (r_hit_ok) o_status <= psm_pkg::StPresent;
                            else if (!r_free_ok) o_status <= psm_pkg::StFull;
                            else begin
                                o_status <= psm_pkg::StOk;
                                r_valid[r_free] <= 1'b1;
                            end
                        end
                        psm_pkg::OpErase: begin
                            if (r_hit_ok) begin
                                o_status <= psm_pkg::StOk;
                                r_valid[r_hit] <= 1'b0;
                            end else begin
                                o_status <= psm_pkg::StNotFnd;
                            end
                        end
                        default: o_status <= psm_pkg::StNotFnd;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/page_slot_hash_map.sv =====
// Top level of the page slot map: request queue front end plus scanning back end.
// Depends on psm_pkg, psm_front, psm_back.
`default_nettype none
// Page slot map: maps a (file_id, page_number) key to a 6-bit buffer slot,
// up to 64 entries, each key at most once. Opcodes: find, insert, erase; every
// request beat gives exactly one result beat (status, slot_out). A two-deep
// request queue takes beats while the back end works. The back end reads the
// entry store one entry per cycle through a single read port, sweeping all
// entries for each request; the result sits in an output register until
// taken. Entry valid bits clear at reset; no clearing pass is needed.
module page_slot_hash_map (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_opcode,
    input  wire  [15:0] i_file_id,
    input  wire  [31:0] i_page_number,
    input  wire  [5:0]  i_slot_value,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot_out
);
    psm_pkg::t_req w_in_req, w_q_req;
    logic w_q_valid, w_q_ready;

    assign w_in_req.opcode = i_opcode;
    assign w_in_req.key    = {i_file_id, i_page_number};
    assign w_in_req.slot   = i_slot_value;

    psm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(w_in_req),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_req(w_q_req)
    );

    psm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_req(w_q_req),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_slot(o_slot_out)
    );

    // a failed find or any non-ok status carries a zero slot
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != psm_pkg::StOk |-> o_slot_out == 6'd0)
        else $error("nonzero slot on failed request");
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_slot_out))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
